[rtl/rsmf_pkg.sv]
// Shared types, constants and helper functions for the range scan minimum finder.
`timescale 1ns / 1ps

package rsmf_pkg;

    // Width of the internal angle accumulator; angles wrap modulo 2^ANGLE_BITS.
    localparam int ANGLE_BITS    = 24;
    localparam int RANGE_W       = 16;
    localparam int ANGLE_START_W = 19;
    localparam int ANGLE_STEP_W  = 13;
    localparam int OUT_ANGLE_W   = 24;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 19;
    localparam int OUTQ_DEPTH    = 4;
    localparam int OUTQ_PTR_W    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W    = $clog2(OUTQ_DEPTH + 1);

    localparam logic [RANGE_W-1:0]              RANGE_MIN_RESET   = 16'd450;
    localparam logic [RANGE_W-1:0]              RANGE_MAX_RESET   = 16'd10000;
    localparam logic [RANGE_W-1:0]              JUMP_RESET        = 16'd200;
    localparam logic signed [ANGLE_START_W-1:0] ANGLE_START_RESET = -19'sd32768;
    localparam logic [ANGLE_STEP_W-1:0]         ANGLE_STEP_RESET  = 13'd105;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RANGE_MIN   = 3'd0,
        CFG_RANGE_MAX   = 3'd1,
        CFG_JUMP        = 3'd2,
        CFG_ANGLE_START = 3'd3,
        CFG_ANGLE_STEP  = 3'd4
    } cfg_index_t;

    typedef logic signed [ANGLE_BITS-1:0] angle_t;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               last_in_scan;
    } sample_t;

    typedef struct packed {
        logic [RANGE_W-1:0]            minimum_range_mm;
        logic signed [OUT_ANGLE_W-1:0] minimum_angle;
        logic                          is_minimum;
        logic                          end_of_scan;
    } result_t;

    typedef struct packed {
        logic [RANGE_W-1:0]              range_min_mm;
        logic [RANGE_W-1:0]              range_max_mm;
        logic [RANGE_W-1:0]              jump_mm;
        logic signed [ANGLE_START_W-1:0] angle_start;
        logic [ANGLE_STEP_W-1:0]         angle_step;
    } cfg_t;

    // Up to two results produced by one sample, in order res0 then res1.
    typedef struct packed {
        logic [1:0] count;
        result_t    res1;
        result_t    res0;
    } result_pair_t;

    // Second stage: the previous object and whether ranges are falling.
    typedef struct packed {
        logic               valid;
        logic [RANGE_W-1:0] range_mm;
        angle_t             angle;
        logic               descending;
    } object_track_t;

    typedef struct packed {
        object_track_t track;
        logic          emit;
        result_t       res;
    } feed_t;

    function automatic angle_t start_angle(input logic signed [ANGLE_START_W-1:0] s);
        return ANGLE_BITS'(s);
    endfunction

    function automatic logic signed [OUT_ANGLE_W-1:0] out_angle(input angle_t a);
        return OUT_ANGLE_W'(a);
    endfunction

    // Hands a closed object to the second stage. When it is not nearer than the
    // previous object and ranges were falling, the previous object is a minimum.
    function automatic feed_t feed_object(input object_track_t t,
                                          input logic [RANGE_W-1:0] r,
                                          input angle_t a);
        feed_t f;
        f.emit                 = 1'b0;
        f.res.minimum_range_mm = t.range_mm;
        f.res.minimum_angle    = out_angle(t.angle);
        f.res.is_minimum       = 1'b1;
        f.res.end_of_scan      = 1'b0;
        if (!t.valid || (r < t.range_mm)) begin
            f.track.descending = 1'b1;
        end else begin
            f.emit             = t.descending;
            f.track.descending = 1'b0;
        end
        f.track.valid    = 1'b1;
        f.track.range_mm = r;
        f.track.angle    = a;
        return f;
    endfunction

    // Appends a result; anything beyond two per sample is dropped.
    function automatic result_pair_t add_result(input result_pair_t p, input result_t r);
        result_pair_t q;
        q = p;
        unique case (p.count)
            2'd0: begin
                q.res0  = r;
                q.count = 2'd1;
            end
            2'd1: begin
                q.res1  = r;
                q.count = 2'd2;
            end
            default: begin
                q = p;
            end
        endcase
        return q;
    endfunction

endpackage

[rtl/range_scan_minimum_finder.sv]
// Top level of the range scan minimum finder.
//
// Range samples enter on the s_ channel, one transfer per sample, with
// last_in_scan on the final sample of a scan. Local-minimum objects leave on
// the m_ channel; the final result of each scan carries end_of_scan, and a
// scan with no minimum yields one empty marker with is_minimum low.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata; the
// user must write it only while the block is idle, which the block does not
// enforce. A write to the angle start also reloads the sample angle unless a
// sample is processed as the reload strobe arrives. Each sample waits in the
// input register until the queue has room, then its results enter the queue.
// Throughput: one sample per cycle while the queue has room; the four-entry
// queue drains one result per cycle, so samples yielding two results can hold
// the input back. When the receiver stalls the queue fills and s_ready falls
// once fewer than two entries are free; nothing is lost.
// Reset (aresetn low, synchronous) restores the register defaults, clears
// both segmentation stages and empties the result queue.
`timescale 1ns / 1ps

module range_scan_minimum_finder
    import rsmf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  sample_t                s_item,
    output logic                   m_valid,
    input  logic                   m_ready,
    output result_t                m_result,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t         cfg;
    logic         angle_reload;
    logic         q_space;
    logic         push_valid;
    result_pair_t push_pair;

    rsmf_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .cfg          (cfg),
        .angle_reload (angle_reload)
    );

    rsmf_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .cfg          (cfg),
        .angle_reload (angle_reload),
        .q_space      (q_space),
        .push_valid   (push_valid),
        .push_pair    (push_pair)
    );

    rsmf_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_pair  (push_pair),
        .q_space    (q_space),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_result   (m_result)
    );

    // Only the final result of a pair may close a scan.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid && (push_pair.count == 2'd2) |-> !push_pair.res0.end_of_scan)
        else $error("end of scan flagged on the first of two results");

    // The queue is never written without room for a full pair.
    assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> q_space)
        else $error("result queue written while short of space");

    // An empty marker only closes a scan and carries zero range and angle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result.is_minimum |->
            m_result.end_of_scan && (m_result.minimum_range_mm == '0)
            && (m_result.minimum_angle == '0))
        else $error("malformed empty end-of-scan marker");

    // Nothing is offered straight after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result offered directly after reset");

endmodule

[rtl/rsmf_cfg.sv]
// Configuration register bank with a reload strobe for the sample angle.
`timescale 1ns / 1ps

module rsmf_cfg
    import rsmf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg,
    output logic                   angle_reload
);

    cfg_t cfg_reg;
    logic reload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.range_min_mm <= RANGE_MIN_RESET;
            cfg_reg.range_max_mm <= RANGE_MAX_RESET;
            cfg_reg.jump_mm      <= JUMP_RESET;
            cfg_reg.angle_start  <= ANGLE_START_RESET;
            cfg_reg.angle_step   <= ANGLE_STEP_RESET;
            reload_reg           <= 1'b0;
        end else begin
            reload_reg <= cfg_wr_en && (cfg_index_t'(cfg_index) == CFG_ANGLE_START);
            if (cfg_wr_en) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_RANGE_MIN:   cfg_reg.range_min_mm <= cfg_wdata[RANGE_W-1:0];
                    CFG_RANGE_MAX:   cfg_reg.range_max_mm <= cfg_wdata[RANGE_W-1:0];
                    CFG_JUMP:        cfg_reg.jump_mm      <= cfg_wdata[RANGE_W-1:0];
                    CFG_ANGLE_START: begin
                        cfg_reg.angle_start <= signed'(cfg_wdata[ANGLE_START_W-1:0]);
                    end
                    CFG_ANGLE_STEP:  cfg_reg.angle_step   <= cfg_wdata[ANGLE_STEP_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // The strobe rises in the cycle after the write, so the new start value is in place.
    assign cfg          = cfg_reg;
    assign angle_reload = reload_reg;

endmodule

[rtl/rsmf_core.sv]
// Input reg, object segmentation, local-minimum detection; one sample per cycle if q_space.
`timescale 1ns / 1ps

module rsmf_core
    import rsmf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  sample_t      s_item,
    input  cfg_t         cfg,
    input  logic         angle_reload,
    input  logic         q_space,
    output logic         push_valid,
    output result_pair_t push_pair
);

    logic               in_valid_reg;
    sample_t            in_item_reg;
    angle_t             sample_angle_reg;
    logic               prev_sample_valid_reg;
    logic [RANGE_W-1:0] prev_sample_range_reg;
    logic [RANGE_W-1:0] obj_min_range_reg;
    angle_t             obj_min_angle_reg;
    object_track_t      track_reg;

    logic [RANGE_W-1:0] obj_min_range_next;
    angle_t             obj_min_angle_next;
    object_track_t      track_next;

    logic               fire;
    logic               sample_ok;
    logic [RANGE_W-1:0] sample_range;
    logic [RANGE_W-1:0] range_diff;
    feed_t              feed_close;
    feed_t              feed_flush;
    result_pair_t       pair;
    result_t            marker;

    assign fire    = in_valid_reg && q_space;
    assign s_ready = !in_valid_reg || q_space;

    assign sample_range = in_item_reg.range_mm;
    assign sample_ok    = (sample_range > cfg.range_min_mm) && (sample_range < cfg.range_max_mm);
    assign range_diff   = (sample_range >= prev_sample_range_reg)
                        ? sample_range - prev_sample_range_reg
                        : prev_sample_range_reg - sample_range;

    always_comb begin
        track_next         = track_reg;
        obj_min_range_next = obj_min_range_reg;
        obj_min_angle_next = obj_min_angle_reg;
        pair               = '0;
        marker             = '0;
        feed_close         = feed_object(track_reg, obj_min_range_reg, obj_min_angle_reg);

        if (sample_ok) begin
            if (prev_sample_valid_reg && (range_diff < cfg.jump_mm)) begin
                if (sample_range < obj_min_range_reg) begin
                    obj_min_range_next = sample_range;
                    obj_min_angle_next = sample_angle_reg;
                end
            end else begin
                // A jump closes the open object before this sample starts a new one.
                if (prev_sample_valid_reg) begin
                    track_next = feed_close.track;
                    if (feed_close.emit) begin
                        pair = add_result(pair, feed_close.res);
                    end
                end
                obj_min_range_next = sample_range;
                obj_min_angle_next = sample_angle_reg;
            end
        end else if (prev_sample_valid_reg) begin
            track_next = feed_close.track;
            if (feed_close.emit) begin
                pair = add_result(pair, feed_close.res);
            end
        end

        feed_flush = feed_object(track_next, obj_min_range_next, obj_min_angle_next);

        if (in_item_reg.last_in_scan) begin
            if (sample_ok) begin
                track_next = feed_flush.track;
                if (feed_flush.emit) begin
                    pair = add_result(pair, feed_flush.res);
                end
            end
            if (track_next.descending) begin
                marker.minimum_range_mm = track_next.range_mm;
                marker.minimum_angle    = out_angle(track_next.angle);
                marker.is_minimum       = 1'b1;
                pair = add_result(pair, marker);
            end
            if (pair.count == 2'd0) begin
                pair = add_result(pair, '0);
            end
            if (pair.count == 2'd2) begin
                pair.res1.end_of_scan = 1'b1;
            end else begin
                pair.res0.end_of_scan = 1'b1;
            end
            track_next.valid      = 1'b0;
            track_next.descending = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg          <= 1'b0;
            sample_angle_reg      <= start_angle(ANGLE_START_RESET);
            prev_sample_valid_reg <= 1'b0;
            prev_sample_range_reg <= '0;
            obj_min_range_reg     <= '0;
            obj_min_angle_reg     <= '0;
            track_reg             <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end

            if (fire) begin
                prev_sample_valid_reg <= sample_ok && !in_item_reg.last_in_scan;
                prev_sample_range_reg <= sample_range;
                obj_min_range_reg     <= obj_min_range_next;
                obj_min_angle_reg     <= obj_min_angle_next;
                track_reg             <= track_next;
                if (in_item_reg.last_in_scan) begin
                    sample_angle_reg <= start_angle(cfg.angle_start);
                end else begin
                    sample_angle_reg <= sample_angle_reg + ANGLE_BITS'(cfg.angle_step);
                end
            end else if (angle_reload) begin
                sample_angle_reg <= start_angle(cfg.angle_start);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    assign push_valid = fire && (pair.count != 2'd0);
    assign push_pair  = pair;

endmodule

[rtl/rsmf_outq.sv]
// Result queue: takes up to two results per cycle and presents one at a time.
`timescale 1ns / 1ps

module rsmf_outq
    import rsmf_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         push_valid,
    input  result_pair_t push_pair,
    output logic         q_space,
    output logic         m_valid,
    input  logic         m_ready,
    output result_t      m_result
);

    result_t               entry_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] wr_ptr_reg;
    logic [OUTQ_PTR_W-1:0] rd_ptr_reg;
    logic [OUTQ_CNT_W-1:0] count_reg;
    logic [OUTQ_CNT_W-1:0] push_n;
    logic                  pop;

    assign pop    = m_valid && m_ready;
    assign push_n = push_valid ? OUTQ_CNT_W'(push_pair.count) : '0;

    // Room for a full pair, judged on the stored count alone.
    assign q_space = (count_reg <= OUTQ_CNT_W'(OUTQ_DEPTH - 2));
    assign m_valid = (count_reg != '0);
    assign m_result = entry_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OUTQ_PTR_W'(push_n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OUTQ_PTR_W'(1);
            end
            count_reg <= count_reg + push_n - OUTQ_CNT_W'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entry_mem[wr_ptr_reg] <= push_pair.res0;
            if (push_pair.count == 2'd2) begin
                entry_mem[wr_ptr_reg + OUTQ_PTR_W'(1)] <= push_pair.res1;
            end
        end
    end

endmodule
